### rtl/core/mts_pkg.sv
// mts_pkg: shared types and constants for the min tracking stack
// used by mts_cell and min_tracking_stack; no dependencies
package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int FILL_W      = 7;

	localparam logic [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// one stack entry plus the minimum of it and every entry beneath it
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [VAL_W-1:0] min;
	} entry_t;

	// shift command broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

### rtl/core/mts_cell.sv
// mts_cell: one slot of the stack chain, shifts toward the bottom on push
// and toward the top on pop; depends on mts_pkg
module mts_cell
	import mts_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    from_up,
	input  entry_t    from_dn,
	output entry_t    slot
);

	entry_t slot_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			slot_q <= from_up;
		end else if (ctl.pop) begin
			slot_q <= from_dn;
		end
	end

	assign slot = slot_q;

endmodule

### rtl/core/min_tracking_stack.sv
// min_tracking_stack: bounded lifo of signed 32-bit values with running minimum
// built from a chain of mts_cell slots; depends on mts_pkg and mts_cell
//
// usage: drive mode and value and raise start; a beat is taken at a rising
// edge with start high and busy low. busy stays low, so a new beat may be
// taken in every cycle. each beat gives one result on the next cycle: done
// is high for exactly that one cycle together with top_value, min_value,
// fill_count, is_empty and status. throughput is one beat
// per cycle, for push and pop alike: each cell keeps the minimum of its own
// entry and everything beneath it, so a pop exposes the next minimum at once
// as the chain shifts. a push when full or a pop when empty leaves the stack
// as it is and reports the refusal in status. the receiver cannot stall and
// must take each result in its cycle. reset empties the stack (fill count
// zero, minimum at the largest integer) with no clearing pass; entry slots
// hold no reset value and are never shown until written.
module min_tracking_stack
	import mts_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    mode,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic signed [VAL_W-1:0] top_value,
	output logic signed [VAL_W-1:0] min_value,
	output logic [FILL_W-1:0]       fill_count,
	output logic                    is_empty,
	output logic [1:0]              status
);

	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic [VAL_W-1:0] top_q;
	logic [VAL_W-1:0] min_q;
	status_t          status_q;

	entry_t           slots [STACK_DEPTH];
	entry_t           push_entry;
	cell_ctl_t        ctl;
	logic             accept;
	logic             is_full;
	logic             no_entry;
	logic             last_one;
	logic [CNT_W-1:0] count_d;
	logic [VAL_W-1:0] top_d;
	logic [VAL_W-1:0] min_d;
	status_t          status_d;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign no_entry = (count_q == '0);
	assign last_one = (count_q == CNT_W'(1));

	always_comb begin
		push_entry.val = value;
		if (no_entry || ($signed(value) < $signed(slots[0].min))) begin
			push_entry.min = value;
		end else begin
			push_entry.min = slots[0].min;
		end
	end

	always_comb begin
		ctl.push = accept && (mode == MODE_PUSH) && !is_full;
		ctl.pop  = accept && (mode == MODE_POP) && !no_entry;
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_DONE;
		top_d    = no_entry ? '0 : slots[0].val;
		min_d    = no_entry ? INT_MAX : slots[0].min;
		if (ctl.push) begin
			count_d = CNT_W'(count_q + 1'b1);
			top_d   = push_entry.val;
			min_d   = push_entry.min;
		end else if (ctl.pop) begin
			count_d = CNT_W'(count_q - 1'b1);
			top_d   = last_one ? '0 : slots[1].val;
			min_d   = last_one ? INT_MAX : slots[1].min;
		end else if (mode == MODE_PUSH) begin
			status_d = ST_FULL;
		end else begin
			status_d = ST_EMPTY;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		entry_t up_in;
		entry_t dn_in;
		if (i == 0) begin : g_top
			assign up_in = push_entry;
		end else begin : g_mid
			assign up_in = slots[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bot
			assign dn_in = slots[i];
		end else begin : g_inner
			assign dn_in = slots[i+1];
		end
		mts_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.from_up (up_in),
			.from_dn (dn_in),
			.slot    (slots[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= top_d;
			min_q    <= min_d;
			status_q <= status_d;
		end
	end

	assign done       = done_q;
	assign top_value  = top_q;
	assign min_value  = min_q;
	assign fill_count = FILL_W'(count_q);
	assign is_empty   = (count_q == '0);
	assign status     = status_q;

	a_beat_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat gave no result");

	a_min_not_above_top: assert property (@(posedge clk) disable iff (!arst_n)
		done && !is_empty |-> min_value <= top_value)
		else $error("minimum above top entry");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> (min_q == INT_MAX) && (top_q == '0))
		else $error("empty stack shows stale top or minimum");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status_q == ST_FULL) |-> count_q == CNT_W'(STACK_DEPTH))
		else $error("push refused while not full");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("push did not advance fill count");

endmodule

### bench/min_tracking_stack_checker.sv
// min_tracking_stack_checker: predicts every result of the min tracking stack
// from the accepted beats and compares the results beat by beat; uses mts_pkg
module min_tracking_stack_checker
	import mts_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    mode,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    done,
	input  logic signed [VAL_W-1:0] top_value,
	input  logic signed [VAL_W-1:0] min_value,
	input  logic [FILL_W-1:0]       fill_count,
	input  logic                    is_empty,
	input  logic [1:0]              status,
	output int                      fail_count,
	output int                      pending_count
);

	typedef struct packed {
		logic signed [VAL_W-1:0] top;
		logic signed [VAL_W-1:0] low;
		logic [FILL_W-1:0]       fill;
		logic                    empty;
		status_t                 status;
	} stack_view_t;

	logic signed [VAL_W-1:0] shadow_entries [STACK_DEPTH];
	int                      shadow_depth;
	logic signed [VAL_W-1:0] shadow_min;
	stack_view_t             awaited_views [$];
	int                      mismatches = 0;

	// applies one push or pop to the shadow stack and returns what the block should show
	function automatic stack_view_t apply_stack_op(logic op, logic signed [VAL_W-1:0] v);
		stack_view_t             view;
		logic signed [VAL_W-1:0] gone;
		view.status = ST_DONE;
		if (op == MODE_PUSH) begin
			if (shadow_depth >= STACK_DEPTH) begin
				view.status = ST_FULL;
			end else begin
				shadow_entries[shadow_depth] = v;
				if (shadow_depth == 0 || v < shadow_min)
					shadow_min = v;
				shadow_depth++;
			end
		end else if (shadow_depth == 0) begin
			view.status = ST_EMPTY;
			shadow_min  = INT_MAX;
		end else begin
			gone = shadow_entries[shadow_depth - 1];
			shadow_depth--;
			// removing an entry at or below the minimum needs a rescan
			if (!(shadow_min < gone)) begin
				shadow_min = INT_MAX;
				for (int i = 0; i < shadow_depth; i++)
					if (shadow_entries[i] < shadow_min)
						shadow_min = shadow_entries[i];
			end
			if (shadow_depth == 0)
				shadow_min = INT_MAX;
		end
		view.top   = (shadow_depth == 0) ? '0 : shadow_entries[shadow_depth - 1];
		view.low   = shadow_min;
		view.fill  = shadow_depth[FILL_W-1:0];
		view.empty = (shadow_depth == 0);
		return view;
	endfunction

	function automatic void check_field(string field, logic [VAL_W-1:0] want,
			logic [VAL_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, $signed(want), $signed(got));
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_view_t want;
		if (!arst_n) begin
			shadow_depth = 0;
			shadow_min   = INT_MAX;
			awaited_views.delete();
		end else begin
			if (start && !busy)
				awaited_views.insert(awaited_views.size(), apply_stack_op(mode, value));
			if (done) begin
				if (awaited_views.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none, actual top %0d",
						$time, top_value);
				end else begin
					want = awaited_views.pop_front();
					check_field("top_value", want.top, top_value);
					check_field("min_value", want.low, min_value);
					check_field("fill_count", {25'd0, want.fill}, {25'd0, fill_count});
					check_field("is_empty", {31'd0, want.empty}, {31'd0, is_empty});
					check_field("status", {30'd0, want.status}, {30'd0, status});
				end
			end
		end
		fail_count    <= mismatches;
		pending_count <= awaited_views.size();
	end

endmodule

### bench/min_tracking_stack_tb.sv
// min_tracking_stack_tb: drives push and pop beats into the min tracking stack
// under several idling phases and reports the verdict; uses mts_pkg and the checker
module min_tracking_stack_tb;
	import mts_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    mode;
	logic signed [VAL_W-1:0] value;
	logic                    done;
	logic signed [VAL_W-1:0] top_value;
	logic signed [VAL_W-1:0] min_value;
	logic [FILL_W-1:0]       fill_count;
	logic                    is_empty;
	logic [1:0]              status;
	int                      fail_count;
	int                      pending_count;

	int idle_pct;
	int beats_sent;

	localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	min_tracking_stack DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.value(value), .done(done), .top_value(top_value), .min_value(min_value),
		.fill_count(fill_count), .is_empty(is_empty), .status(status)
	);

	min_tracking_stack_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.value(value), .done(done), .top_value(top_value), .min_value(min_value),
		.fill_count(fill_count), .is_empty(is_empty), .status(status),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("min_tracking_stack regression: fail");
		$finish;
	end

	task automatic send_beat(input logic op, input logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode  <= op;
		value <= v;
		do @(posedge clk); while (busy);
		beats_sent++;
	endtask

	// extremes and clustered small values so duplicates of the minimum are common
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return INT_MAX;
			1:       return INT_MIN;
			2, 3, 4: return $signed($urandom_range(8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// a run of beats with a given push bias; drives fill and drain walks
	task automatic run_walk(input int count, input int push_pct);
		for (int i = 0; i < count; i++)
			send_beat(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP, pick_value());
	endtask

	task automatic run_phase(input int pct, input int budget);
		int stop_at;
		idle_pct = pct;
		stop_at  = beats_sent + budget;
		// fill past full, then drain past empty
		run_walk(STACK_DEPTH + 4, 100);
		run_walk(STACK_DEPTH + 4, 0);
		while (beats_sent < stop_at) begin
			case ($urandom_range(2))
				0:       run_walk($urandom_range(20, 120), 90);
				1:       run_walk($urandom_range(20, 120), 15);
				default: run_walk($urandom_range(20, 120), 55);
			endcase
		end
	endtask

	initial begin
		int guard;
		start      <= 1'b0;
		mode       <= MODE_PUSH;
		value      <= '0;
		arst_n     <= 1'b0;
		idle_pct   = 0;
		beats_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_beat(MODE_POP, 32'sd7);
		send_beat(MODE_PUSH, INT_MAX);
		send_beat(MODE_PUSH, INT_MIN);
		send_beat(MODE_PUSH, 32'sd0);
		send_beat(MODE_PUSH, INT_MIN);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, -32'sd1);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_PUSH, -32'sd1);
		send_beat(MODE_PUSH, 32'sd5);
		send_beat(MODE_PUSH, -32'sd1);
		send_beat(MODE_PUSH, 32'sh5555_5555);
		send_beat(MODE_PUSH, 32'shAAAA_AAAA);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);
		send_beat(MODE_POP, '0);

		// random phases: no idling, sender idle with a chance of 79 percent, then 23 percent
		run_phase(0, 600);
		run_phase(79, 600);
		run_phase(23, 600);

		start <= 1'b0;
		guard = 0;
		while (pending_count != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_count != 0)
			$display("%0t: results never arrived, expected 0 pending, actual %0d",
				$time, pending_count);
		if (fail_count == 0 && pending_count == 0)
			$display("min_tracking_stack regression: pass");
		else
			$display("min_tracking_stack regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/core/mts_pkg.sv
rtl/core/mts_cell.sv
rtl/core/min_tracking_stack.sv
bench/min_tracking_stack_checker.sv
bench/min_tracking_stack_tb.sv
